[sv/top_k_nearest_select_assert.svh]
// Assertion macros for the top-k select RTL
`ifndef TOP_K_NEAREST_SELECT_ASSERT_SVH
`define TOP_K_NEAREST_SELECT_ASSERT_SVH

// implication checked every cycle outside reset
`define TKNS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("top_k_nearest_select assertion failed");

// next-cycle implication
`define TKNS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("top_k_nearest_select assertion failed");

`endif

[sv/tkns_pkg.sv]
// Types, codes and ordering function for the top-k select block
package tkns_pkg;

  localparam int unsigned DistW = 32;
  localparam int unsigned LabelW = 32;
  localparam int unsigned KW = 6;
  localparam logic [KW-1:0] KReset = 6'd10;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [DistW-1:0] dval;
    logic [LabelW-1:0] lab;
  } entry_t;

  // true if a orders above b: distance first, larger label breaks ties
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.dval != b.dval) begin
      r = ($signed(a.dval) > $signed(b.dval));
    end else begin
      r = (a.lab > b.lab);
    end
    return r;
  endfunction

endpackage

[sv/tkns_mem.sv]
// Entry memory: one write port, one read port with registered data
module tkns_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AW = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  tkns_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output tkns_pkg::entry_t  rdata_o
);

  tkns_pkg::entry_t mem_q [Depth];
  tkns_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/top_k_nearest_select.sv]
// Top level of the top-k nearest candidate selector
//
// Input channel (in_valid_i / in_stall_o) takes requests: operation 0
// offers a candidate (found, distance, label), operation 1 drains.
// Output channel (out_valid_o / out_stall_i) carries drain results,
// largest entry first, last_o on the final one. An empty drain gives
// one result with valid_res_o low and last_o high.
// Held entries live in a one-port-read synchronous memory; each found
// offer or drain scans the held entries one per cycle (duplicate label,
// current max). A miss (found low) is taken without a scan. One request
// is worked at a time; in_stall_o is high while a request is in progress.
// A result waits in the output register while out_stall_i is high.
// Reset empties the store (count to zero) and sets k_count to 10;
// memory contents need no clearing.
// k_count is written through the APB port at address 0.
`include "top_k_nearest_select_assert.svh"

module top_k_nearest_select #(
  parameter int unsigned MAX_K = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic                           found_i,
  input  logic signed [tkns_pkg::DistW-1:0]  distance_i,
  input  logic [tkns_pkg::LabelW-1:0]    label_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           valid_res_o,
  output logic signed [tkns_pkg::DistW-1:0]  out_distance_o,
  output logic [tkns_pkg::LabelW-1:0]    out_label_o,
  output logic                           last_o
);

  localparam int unsigned HW = $clog2(MAX_K + 1);
  localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = (HW > tkns_pkg::KW) ? HW + 1 : tkns_pkg::KW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic [tkns_pkg::KW-1:0] k_q;
  logic [HW-1:0] held_q;
  logic [HW-1:0] idx_q;
  logic [HW-1:0] pidx_q;
  logic pv_q;
  logic op_q;
  tkns_pkg::entry_t req_q, best_q, top_q;
  logic [AW-1:0] best_idx_q;
  logic dup_q;
  logic out_valid_q, valid_res_q, last_q;
  tkns_pkg::entry_t out_q;

  tkns_pkg::entry_t rdata;
  logic we;
  logic [AW-1:0] waddr;
  tkns_pkg::entry_t wdata;

  logic [CW-1:0] k_ext, keff;
  logic cfg_wr;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
  assign prdata = (paddr == 3'd0) ? {{(32 - tkns_pkg::KW){1'b0}}, k_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= tkns_pkg::KReset;
    end else if (cfg_wr) begin
      k_q <= pwdata[tkns_pkg::KW-1:0];
    end
  end

  assign k_ext = CW'(k_q);
  always_comb begin
    keff = k_ext;
    if (k_ext == '0) begin
      keff = CW'(1);
    end else if (k_ext > CW'(MAX_K)) begin
      keff = CW'(MAX_K);
    end
  end

  // memory write, only in decide
  always_comb begin
    we = 1'b0;
    waddr = best_idx_q;
    wdata = req_q;
    if (state_q == ST_DECIDE) begin
      if (op_q == tkns_pkg::OP_OFFER) begin
        if (!dup_q) begin
          if (CW'(held_q) < keff) begin
            we = 1'b1;
            waddr = held_q[AW-1:0];
          end else if (held_q != '0 && $signed(req_q.dval) < $signed(best_q.dval)) begin
            we = 1'b1;
          end
        end
      end else if (held_q != '0) begin
        we = 1'b1;
        wdata = top_q;
      end
    end
  end

  tkns_mem #(
    .Depth(MAX_K),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  logic in_acc, out_acc;
  assign in_acc = in_valid_i && (state_q == ST_IDLE);
  assign out_acc = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      idx_q       <= '0;
      pidx_q      <= '0;
      pv_q        <= 1'b0;
      op_q        <= tkns_pkg::OP_OFFER;
      dup_q       <= 1'b0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
      valid_res_q <= 1'b0;
      last_q      <= 1'b0;
      req_q       <= '0;
      best_q      <= '0;
      top_q       <= '0;
      out_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q      <= operation_i;
            req_q.dval <= distance_i;
            req_q.lab <= label_i;
            dup_q     <= 1'b0;
            idx_q     <= '0;
            pv_q      <= 1'b0;
            if (operation_i == tkns_pkg::OP_DRAIN || found_i) begin
              state_q <= (held_q == '0) ? ST_DECIDE : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pv_q <= (idx_q < held_q);
          if (idx_q < held_q) begin
            idx_q  <= idx_q + HW'(1);
            pidx_q <= idx_q;
          end
          if (pv_q) begin
            if (pidx_q == '0 || tkns_pkg::ranks_above(rdata, best_q)) begin
              best_q     <= rdata;
              best_idx_q <= pidx_q[AW-1:0];
            end
            if (rdata.lab == req_q.lab) begin
              dup_q <= 1'b1;
            end
            if (pidx_q == held_q - HW'(1)) begin
              top_q   <= rdata;
              state_q <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (op_q == tkns_pkg::OP_OFFER) begin
            if (!dup_q && CW'(held_q) < keff) begin
              held_q <= held_q + HW'(1);
            end
            state_q <= ST_IDLE;
          end else begin
            out_valid_q <= 1'b1;
            if (held_q == '0) begin
              valid_res_q <= 1'b0;
              out_q       <= '0;
              last_q      <= 1'b1;
            end else begin
              valid_res_q <= 1'b1;
              out_q       <= best_q;
              last_q      <= (held_q == HW'(1));
              held_q      <= held_q - HW'(1);
            end
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            idx_q       <= '0;
            pv_q        <= 1'b0;
            state_q     <= (held_q == '0) ? ST_IDLE : ST_SCAN;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign valid_res_o    = valid_res_q;
  assign out_distance_o = out_q.dval;
  assign out_label_o    = out_q.lab;
  assign last_o         = last_q;

  `TKNS_ASSERT_IMP(a_held_bound, 1'b1, held_q <= HW'(MAX_K))
  `TKNS_ASSERT_IMP(a_out_only_emit, out_valid_q, state_q == ST_EMIT)
  `TKNS_ASSERT_IMP(a_last_empties, out_valid_q && last_q, held_q == '0)
  `TKNS_ASSERT_NXT(a_drain_ends, out_acc && last_q, state_q == ST_IDLE)

endmodule
